@@ sv/lcps_pkg.sv @@
// ----------------------------------------------------------------------------
// lcps_pkg
// Shared types, constants and helpers for the line centroid PID steering block.
// ----------------------------------------------------------------------------
package lcps_pkg;

	localparam int SENSOR_W = 8;
	localparam int SPEED_W  = 8;
	localparam int GAIN_W   = 8;
	localparam int ERR_W    = 4;
	localparam int INTEG_W  = 24;
	localparam int PID_W    = 26;
	localparam int VAL_W    = 27;
	localparam int ADDR_W   = 5;
	localparam int DATA_W   = 32;
	localparam int IN_W     = 16;
	localparam int OUT_W    = 24;

	localparam logic [SENSOR_W-1:0] ALL_SENSORS = 8'hFF;
	localparam logic [3:0] LINE_CENTRE = 4'd3;
	localparam logic signed [INTEG_W-1:0] INTEG_MAX = 24'sh7FFFFF;
	localparam logic signed [INTEG_W-1:0] INTEG_MIN = -24'sh800000;
	localparam logic [SPEED_W-1:0] HELD_SPEED_RST = 8'd180;

	localparam logic [GAIN_W-1:0]  GAIN_P_RST    = 8'd4;
	localparam logic [GAIN_W-1:0]  GAIN_I_RST    = 8'd0;
	localparam logic [GAIN_W-1:0]  GAIN_D_RST    = 8'd1;
	localparam logic [SPEED_W-1:0] MIN_SPEED_RST = 8'd105;
	localparam logic [SPEED_W-1:0] MAX_SPEED_RST = 8'd255;

	typedef enum logic [2:0] {
		REG_GAIN_P    = 3'd0,
		REG_GAIN_I    = 3'd1,
		REG_GAIN_D    = 3'd2,
		REG_MIN_SPEED = 3'd3,
		REG_MAX_SPEED = 3'd4
	} reg_idx_t;

	typedef struct packed {
		logic [GAIN_W-1:0]  gain_p;
		logic [GAIN_W-1:0]  gain_i;
		logic [GAIN_W-1:0]  gain_d;
		logic [SPEED_W-1:0] min_speed;
		logic [SPEED_W-1:0] max_speed;
	} cfg_t;

	typedef struct packed {
		logic accept;
		logic cent;
		logic mult;
		logic accum;
		logic finish;
	} ctrl_cmd_t;

	typedef struct packed {
		logic out_free;
	} dp_status_t;

	// raise to lo first, then lower to hi
	function automatic logic [SPEED_W-1:0] clamp_speed(
		input logic signed [VAL_W-1:0] v,
		input logic [SPEED_W-1:0] lo,
		input logic [SPEED_W-1:0] hi
	);
		logic signed [VAL_W-1:0] lo_e;
		logic signed [VAL_W-1:0] hi_e;
		logic signed [VAL_W-1:0] r;
		lo_e = VAL_W'({1'b0, lo});
		hi_e = VAL_W'({1'b0, hi});
		r = v;
		if (r < lo_e) r = lo_e;
		if (r > hi_e) r = hi_e;
		return r[SPEED_W-1:0];
	endfunction

endpackage

@@ sv/lcps_regs.sv @@
// ----------------------------------------------------------------------------
// lcps_regs
// Configuration register file behind an APB-style port.
// ----------------------------------------------------------------------------
module lcps_regs (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       psel,
	input  logic                       penable,
	input  logic                       pwrite,
	input  logic [lcps_pkg::ADDR_W-1:0] paddr,
	input  logic [lcps_pkg::DATA_W-1:0] pwdata,
	output logic [lcps_pkg::DATA_W-1:0] prdata,
	output logic                       pready,
	output lcps_pkg::cfg_t             cfg
);
	import lcps_pkg::*;

	cfg_t       cfg_q;
	logic       wr_en;
	logic [2:0] idx;

	assign pready = 1'b1;
	assign wr_en  = psel & penable & pwrite & pready;
	assign idx    = paddr[ADDR_W-1:2];
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.gain_p    <= GAIN_P_RST;
			cfg_q.gain_i    <= GAIN_I_RST;
			cfg_q.gain_d    <= GAIN_D_RST;
			cfg_q.min_speed <= MIN_SPEED_RST;
			cfg_q.max_speed <= MAX_SPEED_RST;
		end else if (wr_en) begin
			unique case (idx)
				REG_GAIN_P:    cfg_q.gain_p    <= pwdata[GAIN_W-1:0];
				REG_GAIN_I:    cfg_q.gain_i    <= pwdata[GAIN_W-1:0];
				REG_GAIN_D:    cfg_q.gain_d    <= pwdata[GAIN_W-1:0];
				REG_MIN_SPEED: cfg_q.min_speed <= pwdata[SPEED_W-1:0];
				REG_MAX_SPEED: cfg_q.max_speed <= pwdata[SPEED_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		prdata = '0;
		unique case (idx)
			REG_GAIN_P:    prdata = DATA_W'(cfg_q.gain_p);
			REG_GAIN_I:    prdata = DATA_W'(cfg_q.gain_i);
			REG_GAIN_D:    prdata = DATA_W'(cfg_q.gain_d);
			REG_MIN_SPEED: prdata = DATA_W'(cfg_q.min_speed);
			REG_MAX_SPEED: prdata = DATA_W'(cfg_q.max_speed);
			default:       prdata = '0;
		endcase
	end

endmodule

@@ sv/lcps_ctrl.sv @@
// ----------------------------------------------------------------------------
// lcps_ctrl
// Sequencer: accept, centroid, multiply, accumulate, result.
// ----------------------------------------------------------------------------
module lcps_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  lcps_pkg::dp_status_t status,
	output lcps_pkg::ctrl_cmd_t  cmd
);
	import lcps_pkg::*;

	typedef enum logic [4:0] {
		ST_IDLE  = 5'b00001,
		ST_CENT  = 5'b00010,
		ST_MULT  = 5'b00100,
		ST_ACCUM = 5'b01000,
		ST_DONE  = 5'b10000
	} state_t;

	state_t state_q;
	state_t state_d;

	assign in_ready = (state_q == ST_IDLE);

	always_comb begin
		cmd        = '0;
		cmd.accept = (state_q == ST_IDLE) && in_valid;
		cmd.cent   = (state_q == ST_CENT);
		cmd.mult   = (state_q == ST_MULT);
		cmd.accum  = (state_q == ST_ACCUM);
		cmd.finish = (state_q == ST_DONE) && status.out_free;
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE:  if (in_valid) state_d = ST_CENT;
			ST_CENT:  state_d = ST_MULT;
			ST_MULT:  state_d = ST_ACCUM;
			ST_ACCUM: state_d = ST_DONE;
			ST_DONE:  if (status.out_free) state_d = ST_IDLE;
			default:  state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	a_accept_starts: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.accept |=> state_q == ST_CENT)
		else $error("accepted item did not start the centroid step");

	a_done_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DONE) && !status.out_free |=> state_q == ST_DONE)
		else $error("result step left while the output register was full");

	a_no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != ST_IDLE) |-> !cmd.accept)
		else $error("item accepted while an item is in flight");

endmodule

@@ sv/lcps_dp.sv @@
// ----------------------------------------------------------------------------
// lcps_dp
// Datapath: run flag, centroid error, PID terms, speed clamp, output register.
// ----------------------------------------------------------------------------
module lcps_dp (
	input  logic                          clk,
	input  logic                          arst_n,
	input  lcps_pkg::cfg_t                cfg,
	input  lcps_pkg::ctrl_cmd_t           cmd,
	output lcps_pkg::dp_status_t          status,
	input  logic [lcps_pkg::SENSOR_W-1:0] in_bits,
	input  logic                          in_toggle,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic                          out_running,
	output logic [lcps_pkg::SPEED_W-1:0]  out_speed_a,
	output logic [lcps_pkg::SPEED_W-1:0]  out_speed_b,
	output logic signed [lcps_pkg::ERR_W-1:0] out_line_error,
	output logic                          out_line_lost
);
	import lcps_pkg::*;

	// persistent state
	logic                        run_q;
	logic signed [INTEG_W-1:0]   integral_q;
	logic signed [ERR_W-1:0]     prev_err_q;
	logic [SPEED_W-1:0]          held_a_q;
	logic [SPEED_W-1:0]          held_b_q;

	// per-item working registers
	logic [SENSOR_W-1:0]         bits_q;
	logic signed [ERR_W-1:0]     err_q;
	logic                        lost_q;
	logic signed [12:0]          pprod_q;
	logic signed [12:0]          iprod_q;
	logic signed [13:0]          dprod_q;
	logic signed [PID_W-1:0]     pid_q;

	// output register
	logic                        out_valid_q;
	logic                        out_running_q;
	logic [SPEED_W-1:0]          out_a_q;
	logic [SPEED_W-1:0]          out_b_q;
	logic signed [ERR_W-1:0]     out_err_q;
	logic                        out_lost_q;

	logic                        run_next;
	logic [3:0]                  cnt;
	logic [4:0]                  sum;
	logic [6:0]                  ge;
	logic [2:0]                  quot;
	logic signed [ERR_W-1:0]     err_d;
	logic signed [4:0]           diff;
	logic signed [INTEG_W:0]     integ_raw;
	logic signed [INTEG_W-1:0]   integ_sat;
	logic signed [PID_W-1:0]     pid_d;
	logic [SPEED_W:0]            mid_sum;
	logic signed [VAL_W-1:0]     mid_e;
	logic [SPEED_W-1:0]          speed_a;
	logic [SPEED_W-1:0]          speed_b;

	assign run_next = (run_q ^ in_toggle) & (in_bits != ALL_SENSORS);

	// centroid: popcount, index sum and a quotient by compare against multiples
	always_comb begin
		cnt = '0;
		sum = '0;
		for (int i = 0; i < SENSOR_W; i++) begin
			cnt = cnt + 4'(bits_q[i]);
			sum = sum + (bits_q[i] ? 5'(i) : 5'd0);
		end
		for (int k = 1; k < SENSOR_W; k++) begin
			ge[k-1] = (6'(k) * 6'(cnt)) <= 6'(sum);
		end
		quot = 3'($countones(ge));
		if (cnt == '0) begin
			err_d = prev_err_q;
		end else begin
			err_d = signed'(4'({1'b0, quot}) - LINE_CENTRE);
		end
	end

	assign diff = 5'(err_q) - 5'(prev_err_q);

	// saturating integral, then the PID sum
	always_comb begin
		integ_raw = 25'(integral_q) + 25'(iprod_q);
		if (integ_raw > 25'(INTEG_MAX)) begin
			integ_sat = INTEG_MAX;
		end else if (integ_raw < 25'(INTEG_MIN)) begin
			integ_sat = INTEG_MIN;
		end else begin
			integ_sat = integ_raw[INTEG_W-1:0];
		end
		pid_d = PID_W'(integ_sat) + PID_W'(pprod_q) + PID_W'(dprod_q);
	end

	assign mid_sum = {1'b0, cfg.min_speed} + {1'b0, cfg.max_speed};
	assign mid_e   = VAL_W'({1'b0, mid_sum[SPEED_W:1]});
	assign speed_a = clamp_speed(mid_e - VAL_W'(pid_q), cfg.min_speed, cfg.max_speed);
	assign speed_b = clamp_speed(mid_e + VAL_W'(pid_q), cfg.min_speed, cfg.max_speed);

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			bits_q <= in_bits;
		end
		if (cmd.cent) begin
			err_q  <= err_d;
			lost_q <= (cnt == '0);
		end
		if (cmd.mult) begin
			pprod_q <= 13'(signed'({1'b0, cfg.gain_p})) * 13'(err_q);
			iprod_q <= 13'(signed'({1'b0, cfg.gain_i})) * 13'(err_q);
			dprod_q <= 14'(signed'({1'b0, cfg.gain_d})) * 14'(diff);
		end
		if (cmd.accum) begin
			pid_q <= pid_d;
		end
		if (cmd.finish) begin
			out_running_q <= run_q;
			out_a_q       <= run_q ? speed_a : held_a_q;
			out_b_q       <= run_q ? speed_b : held_b_q;
			out_err_q     <= run_q ? err_q : '0;
			out_lost_q    <= run_q & lost_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q       <= 1'b0;
			integral_q  <= '0;
			prev_err_q  <= '0;
			held_a_q    <= HELD_SPEED_RST;
			held_b_q    <= HELD_SPEED_RST;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.accept) begin
				run_q <= run_next;
			end
			if (cmd.accum && run_q) begin
				integral_q <= integ_sat;
				prev_err_q <= err_q;
			end
			if (cmd.finish && run_q) begin
				held_a_q <= speed_a;
				held_b_q <= speed_b;
			end
			if (cmd.finish) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign status.out_free = !out_valid_q || out_ready;
	assign out_valid       = out_valid_q;
	assign out_running     = out_running_q;
	assign out_speed_a     = out_a_q;
	assign out_speed_b     = out_b_q;
	assign out_line_error  = out_err_q;
	assign out_line_lost   = out_lost_q;

	a_stopped_holds_state: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.accum && !run_q |=> $stable(integral_q) && $stable(prev_err_q))
		else $error("PID state changed while stopped");

	a_finish_sets_valid: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.finish |=> out_valid_q)
		else $error("finished result not presented");

	a_stopped_result_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.finish && !run_q |=> out_err_q == '0 && !out_lost_q)
		else $error("stopped result carries an error or line loss");

endmodule

@@ sv/line_centroid_pid_steering.sv @@
// ----------------------------------------------------------------------------
// line_centroid_pid_steering
// Line-sensor centroid error, PID with saturating integral, clamped motor speeds.
//
//   channel   dir  handshake              payload
//   s_axis    in   tvalid/tready          sensor_bits, toggle_run
//   m_axis    out  tvalid/tready          running, speed_a, speed_b, line_error,
//                                         line_lost
//   apb       in   psel/penable/pready    gain_p, gain_i, gain_d, min_speed,
//                                         max_speed at 0x00..0x10
//
// an item passes accept, centroid, multiply, accumulate, clamp/result in that order;
// the result register loads in the clamp/result step, and the sequencer handles
// one item at a time, so the next transfer is taken the cycle after the
// result is loaded
// the result sits in an output register; a stall there holds the last step
// reset clears the run flag, integral and previous error and sets the held speeds to 180
// ----------------------------------------------------------------------------
module line_centroid_pid_steering (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	// [7:0] sensor_bits, [8] toggle_run, [15:9] zero
	input  logic [lcps_pkg::IN_W-1:0]  s_axis_tdata,
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	// [0] running, [8:1] speed_a, [16:9] speed_b, [20:17] line_error,
	// [21] line_lost, [23:22] zero
	output logic [lcps_pkg::OUT_W-1:0] m_axis_tdata,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [lcps_pkg::ADDR_W-1:0] paddr,
	input  logic [lcps_pkg::DATA_W-1:0] pwdata,
	output logic [lcps_pkg::DATA_W-1:0] prdata,
	output logic        pready
);
	import lcps_pkg::*;

	cfg_t       cfg;
	ctrl_cmd_t  cmd;
	dp_status_t status;

	logic                     out_running;
	logic [SPEED_W-1:0]       out_speed_a;
	logic [SPEED_W-1:0]       out_speed_b;
	logic signed [ERR_W-1:0]  out_line_error;
	logic                     out_line_lost;

	lcps_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	lcps_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_ready (s_axis_tready),
		.status   (status),
		.cmd      (cmd)
	);

	lcps_dp u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg            (cfg),
		.cmd            (cmd),
		.status         (status),
		.in_bits        (s_axis_tdata[SENSOR_W-1:0]),
		.in_toggle      (s_axis_tdata[SENSOR_W]),
		.out_valid      (m_axis_tvalid),
		.out_ready      (m_axis_tready),
		.out_running    (out_running),
		.out_speed_a    (out_speed_a),
		.out_speed_b    (out_speed_b),
		.out_line_error (out_line_error),
		.out_line_lost  (out_line_lost)
	);

	assign m_axis_tdata = {2'b00, out_line_lost, out_line_error, out_speed_b,
		out_speed_a, out_running};

endmodule
